// File: sv/apu_pkg.sv
// Shared types and constants for the alpha premultiply unit.
// No dependencies; used by every module of the block.
package apu_pkg;

    localparam int NUM_LANES = 4;
    localparam int CH_W      = 16;
    localparam int DIV_STEPS = CH_W;          // one quotient bit per stage
    localparam int LANE_DEPTH = DIV_STEPS + 1; // multiply stage + divide stages

    localparam logic [CH_W-1:0] MAX_8  = 16'h00FF;
    localparam logic [CH_W-1:0] MAX_16 = 16'hFFFF;

    // register indexes of the configuration port
    localparam logic [1:0] CFG_DIVIDE_MODE    = 2'd0;
    localparam logic [1:0] CFG_SIXTEEN_BIT    = 2'd1;
    localparam logic [1:0] CFG_CHANNEL_ENABLE = 2'd2;
    localparam logic [1:0] CFG_ALPHA_SOURCE   = 2'd3;

    // alpha source selector codes
    localparam logic [2:0] SRC_NONE  = 3'd0;
    localparam logic [2:0] SRC_RED   = 3'd1;
    localparam logic [2:0] SRC_GREEN = 3'd2;
    localparam logic [2:0] SRC_BLUE  = 3'd3;
    localparam logic [2:0] SRC_ALPHA = 3'd4;

    localparam logic       RST_DIVIDE_MODE    = 1'b0;
    localparam logic       RST_SIXTEEN_BIT    = 1'b0;
    localparam logic [3:0] RST_CHANNEL_ENABLE = 4'd7;
    localparam logic [2:0] RST_ALPHA_SOURCE   = SRC_ALPHA;

    typedef struct packed {
        logic wide;     // 16-bit channels
        logic divide;   // unpremultiply
        logic enable;   // this lane is scaled
    } t_lane_ctl;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] alpha;
    } t_pixel;

endpackage

// File: sv/apu_lane.sv
// One channel lane: shared 16x16 multiplier, constant divide by max,
// and a 16-stage restoring divider for unpremultiply. Uses apu_pkg.
module apu_lane (
    input  logic                    i_clk,
    input  logic                    i_adv,
    input  logic [15:0]             i_c,
    input  logic [15:0]             i_alpha,
    input  apu_pkg::t_lane_ctl      i_ctl,
    output logic [15:0]             o_result
);
    import apu_pkg::*;

    localparam logic [1:0] KIND_FIX = 2'd0;
    localparam logic [1:0] KIND_PRE = 2'd1;
    localparam logic [1:0] KIND_DIV = 2'd2;

    // stage 1
    logic [CH_W-1:0]   s_max;
    logic [CH_W-1:0]   s_mul_b;
    logic [2*CH_W-1:0] n1_prod;
    logic [CH_W-1:0]   n1_fix;
    logic [1:0]        n1_kind;

    logic [2*CH_W-1:0] r1_prod;
    logic [CH_W-1:0]   r1_fix;
    logic [1:0]        r1_kind;
    logic [CH_W-1:0]   r1_alpha;
    logic              r1_wide;

    // premultiply fold: floor(p / (2^k - 1)) with one correction
    logic [CH_W-1:0]   s_q0;
    logic [CH_W:0]     s_r;
    logic [CH_W-1:0]   s_pre;

    // divider stages
    logic [CH_W-1:0] s_rem_in [DIV_STEPS];
    logic [CH_W-1:0] s_dvd_in [DIV_STEPS];
    logic [CH_W-1:0] s_quo_in [DIV_STEPS];
    logic [CH_W-1:0] s_alp_in [DIV_STEPS];
    logic [CH_W-1:0] s_fix_in [DIV_STEPS];
    logic            s_useq_in[DIV_STEPS];

    logic [CH_W-1:0] n_rem [DIV_STEPS];
    logic [CH_W-1:0] n_dvd [DIV_STEPS];
    logic [CH_W-1:0] n_quo [DIV_STEPS];

    logic [CH_W-1:0] r_rem [DIV_STEPS];
    logic [CH_W-1:0] r_dvd [DIV_STEPS];
    logic [CH_W-1:0] r_quo [DIV_STEPS];
    logic [CH_W-1:0] r_alp [DIV_STEPS];
    logic [CH_W-1:0] r_fix [DIV_STEPS];
    logic            r_useq[DIV_STEPS];

    always_comb begin
        s_max   = i_ctl.wide ? MAX_16 : MAX_8;
        s_mul_b = i_ctl.divide ? s_max : i_alpha;
        n1_prod = {16'd0, i_c} * {16'd0, s_mul_b};
        n1_fix  = i_c;
        n1_kind = KIND_FIX;
        if (!i_ctl.enable) begin
            n1_kind = KIND_FIX;
        end else if (!i_ctl.divide) begin
            n1_kind = KIND_PRE;
        end else if (i_alpha == '0) begin
            n1_kind = KIND_FIX;
        end else if (i_c >= i_alpha) begin
            // quotient would reach max or beyond
            n1_fix  = s_max;
            n1_kind = KIND_FIX;
        end else begin
            n1_kind = KIND_DIV;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1_prod  <= n1_prod;
            r1_fix   <= n1_fix;
            r1_kind  <= n1_kind;
            r1_alpha <= i_alpha;
            r1_wide  <= i_ctl.wide;
        end
    end

    always_comb begin
        if (r1_wide) begin
            s_q0 = r1_prod[31:16];
            s_r  = {1'b0, r1_prod[15:0]} + {1'b0, s_q0};
            s_pre = (s_r >= {1'b0, MAX_16}) ? s_q0 + 16'd1 : s_q0;
        end else begin
            s_q0 = {8'd0, r1_prod[15:8]};
            s_r  = {9'd0, r1_prod[7:0]} + {1'b0, s_q0};
            s_pre = (s_r >= {1'b0, MAX_8}) ? s_q0 + 16'd1 : s_q0;
        end
    end

    always_comb begin
        // remainder starts at the upper half: quotient fits in 16 bits
        s_rem_in[0]  = r1_prod[31:16];
        s_dvd_in[0]  = r1_prod[15:0];
        s_quo_in[0]  = '0;
        s_alp_in[0]  = r1_alpha;
        s_fix_in[0]  = (r1_kind == KIND_PRE) ? s_pre : r1_fix;
        s_useq_in[0] = (r1_kind == KIND_DIV);
        for (int j = 1; j < DIV_STEPS; j++) begin
            s_rem_in[j]  = r_rem[j-1];
            s_dvd_in[j]  = r_dvd[j-1];
            s_quo_in[j]  = r_quo[j-1];
            s_alp_in[j]  = r_alp[j-1];
            s_fix_in[j]  = r_fix[j-1];
            s_useq_in[j] = r_useq[j-1];
        end
    end

    always_comb begin
        for (int j = 0; j < DIV_STEPS; j++) begin
            logic [CH_W:0] t;
            logic [CH_W:0] d;
            logic          ge;
            t  = {s_rem_in[j], s_dvd_in[j][CH_W-1]};
            d  = t - {1'b0, s_alp_in[j]};
            ge = (t >= {1'b0, s_alp_in[j]});
            n_rem[j] = ge ? d[CH_W-1:0] : t[CH_W-1:0];
            n_dvd[j] = {s_dvd_in[j][CH_W-2:0], 1'b0};
            n_quo[j] = {s_quo_in[j][CH_W-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int j = 0; j < DIV_STEPS; j++) begin
                r_rem[j]  <= n_rem[j];
                r_dvd[j]  <= n_dvd[j];
                r_quo[j]  <= n_quo[j];
                r_alp[j]  <= s_alp_in[j];
                r_fix[j]  <= s_fix_in[j];
                r_useq[j] <= s_useq_in[j];
            end
        end
    end

    assign o_result = r_useq[DIV_STEPS-1] ? r_quo[DIV_STEPS-1] : r_fix[DIV_STEPS-1];

endmodule

// File: sv/apu_merge.sv
// Merge stage: gathers the four lane results into one pixel and holds it
// in a two-entry skid queue toward the output. Uses apu_pkg.
module apu_merge (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  logic [15:0]         i_lane_res [apu_pkg::NUM_LANES],
    output apu_pkg::t_pixel     o_pixel,
    output logic                o_valid,
    input  logic                i_stall,
    output logic                o_room
);
    import apu_pkg::*;

    t_pixel     s_pix;
    t_pixel     r_buf [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic       s_pop;

    assign s_pix.red   = i_lane_res[0];
    assign s_pix.green = i_lane_res[1];
    assign s_pix.blue  = i_lane_res[2];
    assign s_pix.alpha = i_lane_res[3];

    assign o_valid = (r_cnt != 2'd0);
    assign o_room  = (r_cnt != 2'd2);
    assign s_pop   = o_valid && !i_stall;
    assign o_pixel = r_buf[r_rd_ptr];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !s_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (s_pop && !i_push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr_ptr] <= s_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (s_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_cnt <= n_cnt;
        end
    end

endmodule

// File: sv/alpha_premultiply_unit.sv
// Alpha premultiply / unpremultiply unit, top level. Uses apu_pkg, apu_lane, apu_merge.
// From input beat to output beat a pixel passes the input register, the multiply stage,
// 16 divider stages and the output queue.
// Throughput: one pixel per cycle; the four lanes and the one-bit-per-stage
// divider are fully pipelined. The pipeline holds while the output queue is full.
// Reset: registers return to defaults (premultiply, 8-bit, RGB enabled, alpha source A).
module alpha_premultiply_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [3:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_source_present,
    input  logic [15:0] i_red_in,
    input  logic [15:0] i_green_in,
    input  logic [15:0] i_blue_in,
    input  logic [15:0] i_alpha_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_red_out,
    output logic [15:0] o_green_out,
    output logic [15:0] o_blue_out,
    output logic [15:0] o_alpha_out
);
    import apu_pkg::*;

    logic       r_divide_mode;
    logic       r_sixteen_bit;
    logic [3:0] r_channel_enable;
    logic [2:0] r_alpha_source;

    logic            s_adv;
    logic            s_room;
    logic            s_accept;
    logic [CH_W-1:0] s_mask;
    logic [CH_W-1:0] s_pix [NUM_LANES];
    logic [CH_W-1:0] s_alpha;
    logic            s_src_ok;
    t_lane_ctl       s_ctl [NUM_LANES];

    logic [CH_W-1:0] r_c [NUM_LANES];
    logic [CH_W-1:0] r_alpha;
    t_lane_ctl       r_ctl [NUM_LANES];
    logic [LANE_DEPTH:0] r_vld;

    logic [CH_W-1:0] s_lane_res [NUM_LANES];
    t_pixel          s_out_pix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_divide_mode    <= RST_DIVIDE_MODE;
            r_sixteen_bit    <= RST_SIXTEEN_BIT;
            r_channel_enable <= RST_CHANNEL_ENABLE;
            r_alpha_source   <= RST_ALPHA_SOURCE;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DIVIDE_MODE:    r_divide_mode    <= i_cfg_data[0];
                CFG_SIXTEEN_BIT:    r_sixteen_bit    <= i_cfg_data[0];
                CFG_CHANNEL_ENABLE: r_channel_enable <= i_cfg_data;
                CFG_ALPHA_SOURCE:   r_alpha_source   <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    assign s_adv      = s_room;
    assign o_in_stall = !s_room;
    assign s_accept   = i_in_valid && s_adv;

    always_comb begin
        s_mask = r_sixteen_bit ? MAX_16 : MAX_8;
        // missing source pixel: all channels zero, which every lane maps to zero
        s_pix[0] = i_source_present ? (i_red_in   & s_mask) : '0;
        s_pix[1] = i_source_present ? (i_green_in & s_mask) : '0;
        s_pix[2] = i_source_present ? (i_blue_in  & s_mask) : '0;
        s_pix[3] = i_source_present ? (i_alpha_in & s_mask) : '0;
        s_src_ok = (r_alpha_source inside {[SRC_RED:SRC_ALPHA]});
        case (r_alpha_source)
            SRC_RED:   s_alpha = s_pix[0];
            SRC_GREEN: s_alpha = s_pix[1];
            SRC_BLUE:  s_alpha = s_pix[2];
            SRC_ALPHA: s_alpha = s_pix[3];
            default:   s_alpha = '0;
        endcase
        for (int i = 0; i < NUM_LANES; i++) begin
            s_ctl[i].wide   = r_sixteen_bit;
            s_ctl[i].divide = r_divide_mode;
            s_ctl[i].enable = s_src_ok && r_channel_enable[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_adv) begin
            r_c     <= s_pix;
            r_alpha <= s_alpha;
            r_ctl   <= s_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (s_adv) begin
            r_vld <= {r_vld[LANE_DEPTH-1:0], s_accept};
        end
    end

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        apu_lane u_lane (
            .i_clk    (i_clk),
            .i_adv    (s_adv),
            .i_c      (r_c[g]),
            .i_alpha  (r_alpha),
            .i_ctl    (r_ctl[g]),
            .o_result (s_lane_res[g])
        );
    end

    apu_merge u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (s_adv && r_vld[LANE_DEPTH]),
        .i_lane_res (s_lane_res),
        .o_pixel    (s_out_pix),
        .o_valid    (o_out_valid),
        .i_stall    (i_out_stall),
        .o_room     (s_room)
    );

    assign o_red_out   = s_out_pix.red;
    assign o_green_out = s_out_pix.green;
    assign o_blue_out  = s_out_pix.blue;
    assign o_alpha_out = s_out_pix.alpha;

endmodule

// File: sim/alpha_premultiply_unit_test.sv
// Self-checking testbench for alpha_premultiply_unit: corner and random pixel beats under
// many register settings, checked against an in-bench premultiply/unpremultiply predictor.
// Depends on apu_pkg and the alpha_premultiply_unit RTL.
module alpha_premultiply_unit_test;
    import apu_pkg::*;

    localparam int IDLE_LIMIT    = 5000;  // cycles without any beat before giving up
    localparam int SETTLE_CYCLES = 24;    // pipeline latency plus margin
    localparam int HOLD_CYCLES   = 300;
    localparam int MAX_REPORTS   = 10;

    typedef struct packed {
        logic   present;
        t_pixel px;
    } t_beat;

    typedef enum logic [1:0] {FLOW_FREE, FLOW_LIGHT, FLOW_HEAVY, FLOW_PERIODIC} t_flow;

    class pixel_scoreboard;
        logic       divide_mode;
        logic       sixteen_bit;
        logic [3:0] channel_enable;
        logic [2:0] alpha_source;
        t_pixel     expected_pixels[$];
        int         failures;
        int         pixels_in;
        int         pixels_out;

        function new();
            divide_mode    = RST_DIVIDE_MODE;
            sixteen_bit    = RST_SIXTEEN_BIT;
            channel_enable = RST_CHANNEL_ENABLE;
            alpha_source   = RST_ALPHA_SOURCE;
            failures       = 0;
            pixels_in      = 0;
            pixels_out     = 0;
        endfunction

        function void set_register(logic [1:0] index, logic [3:0] data);
            case (index)
                CFG_DIVIDE_MODE:    divide_mode    = data[0];
                CFG_SIXTEEN_BIT:    sixteen_bit    = data[0];
                CFG_CHANNEL_ENABLE: channel_enable = data;
                CFG_ALPHA_SOURCE:   alpha_source   = data[2:0];
                default: ;
            endcase
        endfunction

        function logic [CH_W-1:0] full_scale();
            return sixteen_bit ? MAX_16 : MAX_8;
        endfunction

        // multiply: floor(c*a/max); divide: min(max, floor(c*max/a)), zero alpha keeps c
        function logic [CH_W-1:0] scaled_level(logic [CH_W-1:0] level,
                                               logic [CH_W-1:0] alpha,
                                               logic [CH_W-1:0] top);
            logic [31:0] quotient;
            if (!divide_mode) begin
                quotient = (32'(level) * 32'(alpha)) / 32'(top);
            end else if (alpha == '0) begin
                quotient = 32'(level);
            end else begin
                quotient = (32'(level) * 32'(top)) / 32'(alpha);
                if (quotient > 32'(top)) quotient = 32'(top);
            end
            return quotient[CH_W-1:0];
        endfunction

        function t_pixel scaled_pixel(t_beat b);
            logic [CH_W-1:0] top;
            logic [CH_W-1:0] lanes [NUM_LANES];
            logic [CH_W-1:0] alpha;
            t_pixel          result;
            if (!b.present) return '0;
            top      = full_scale();
            lanes[0] = b.px.red & top;
            lanes[1] = b.px.green & top;
            lanes[2] = b.px.blue & top;
            lanes[3] = b.px.alpha & top;
            // alpha is taken from the unmodified pixel; spare selector codes act as none
            if (alpha_source >= SRC_RED && alpha_source <= SRC_ALPHA && channel_enable != '0) begin
                alpha = lanes[alpha_source - SRC_RED];
                for (int c = 0; c < NUM_LANES; c++) begin
                    if (channel_enable[c]) lanes[c] = scaled_level(lanes[c], alpha, top);
                end
            end
            result.red   = lanes[0];
            result.green = lanes[1];
            result.blue  = lanes[2];
            result.alpha = lanes[3];
            return result;
        endfunction

        function void note_pixel(t_beat b);
            expected_pixels.push_back(scaled_pixel(b));
            pixels_in++;
        endfunction

        function void check_pixel(t_pixel got);
            t_pixel want;
            pixels_out++;
            if (expected_pixels.size() == 0) begin
                failures++;
                if (failures <= MAX_REPORTS) $display("unexpected output beat %h", got);
                return;
            end
            want = expected_pixels.pop_front();
            if (want.red !== got.red || want.green !== got.green ||
                want.blue !== got.blue || want.alpha !== got.alpha) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("pixel %0d: expected r=%h g=%h b=%h a=%h, got r=%h g=%h b=%h a=%h",
                             pixels_out - 1, want.red, want.green, want.blue, want.alpha,
                             got.red, got.green, got.blue, got.alpha);
            end
        endfunction

        function void close_out();
            if (expected_pixels.size() != 0) begin
                failures += expected_pixels.size();
                $display("%0d expected pixels never came out", expected_pixels.size());
            end
        endfunction
    endclass

    logic        i_clk            = 1'b0;
    logic        i_rst_n          = 1'b0;
    logic        i_cfg_we         = 1'b0;
    logic [1:0]  i_cfg_index      = '0;
    logic [3:0]  i_cfg_data       = '0;
    logic        i_in_valid       = 1'b0;
    logic        i_source_present = 1'b0;
    logic [15:0] i_red_in         = '0;
    logic [15:0] i_green_in       = '0;
    logic [15:0] i_blue_in        = '0;
    logic [15:0] i_alpha_in       = '0;
    logic        i_out_stall      = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [15:0] o_red_out;
    logic [15:0] o_green_out;
    logic [15:0] o_blue_out;
    logic [15:0] o_alpha_out;

    pixel_scoreboard board = new();

    int hold_request   = 0;
    int hold_count     = 0;
    int drain_count    = 0;
    int settings_count = 0;

    alpha_premultiply_unit u_top (.*);

    always #5 i_clk = ~i_clk;

    function automatic t_beat pixel_of(logic present, logic [15:0] r, logic [15:0] g,
                                       logic [15:0] b, logic [15:0] a);
        t_beat beat;
        beat.present  = present;
        beat.px.red   = r;
        beat.px.green = g;
        beat.px.blue  = b;
        beat.px.alpha = a;
        return beat;
    endfunction

    function automatic logic [15:0] random_level(logic [15:0] top);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return top;
            2:       return 16'd1;
            3:       return top - 16'd1;
            4:       return 16'($urandom_range(0, 15));  // small alphas drive saturation
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_beat random_beat();
        logic [15:0] top;
        top = board.full_scale();
        return pixel_of($urandom_range(0, 19) != 0, random_level(top), random_level(top),
                        random_level(top), random_level(top));
    endfunction

    task automatic send_pixel(input t_beat beat);
        i_in_valid       <= 1'b1;
        i_source_present <= beat.present;
        i_red_in         <= beat.px.red;
        i_green_in       <= beat.px.green;
        i_blue_in        <= beat.px.blue;
        i_alpha_in       <= beat.px.alpha;
        do @(posedge i_clk); while (o_in_stall);
        board.note_pixel(beat);
    endtask

    task automatic pause_sender(input int cycles);
        i_in_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (board.expected_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // narrow registers get random upper data bits; the block must ignore them
    task automatic apply_settings(input logic divide, input logic wide,
                                  input logic [3:0] enables, input logic [2:0] src_code);
        logic [3:0] words [4];
        words[CFG_DIVIDE_MODE]    = {3'($urandom), divide};
        words[CFG_SIXTEEN_BIT]    = {3'($urandom), wide};
        words[CFG_CHANNEL_ENABLE] = enables;
        words[CFG_ALPHA_SOURCE]   = {1'($urandom), src_code};
        wait_drained();
        for (int r = 0; r < 4; r++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= 2'(r);
            i_cfg_data  <= words[r];
            @(posedge i_clk);
            board.set_register(2'(r), words[r]);
        end
        i_cfg_we <= 1'b0;
        settings_count++;
    endtask

    task automatic send_stream(input int count, input bit with_gaps);
        int burst_left;
        burst_left = $urandom_range(1, 24);
        for (int n = 0; n < count; n++) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                if (with_gaps) pause_sender($urandom_range(1, 8));
            end
            send_pixel(random_beat());
            burst_left--;
        end
    endtask

    task automatic run_phase(input logic divide, input logic wide, input logic [3:0] enables,
                             input logic [2:0] src_code, input int count, input bit with_gaps);
        apply_settings(divide, wide, enables, src_code);
        send_stream(count, with_gaps);
    endtask

    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) quiet_cycles = 0;
            else quiet_cycles++;
        end
        $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
        $display("alpha_premultiply_unit regression: fail");
        $finish;
    end

    initial begin : receiver
        int     hold_left;
        int     pattern_left;
        int     tick;
        t_flow  flow;
        t_pixel seen;
        hold_left    = 0;
        pattern_left = 0;
        tick         = 0;
        flow         = FLOW_FREE;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                seen = '{red: o_red_out, green: o_green_out, blue: o_blue_out,
                         alpha: o_alpha_out};
                board.check_pixel(seen);
            end
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            tick++;
            if (hold_left != 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                if (pattern_left == 0) begin
                    flow         = t_flow'($urandom_range(0, 3));
                    pattern_left = $urandom_range(16, 120);
                end
                pattern_left--;
                case (flow)
                    FLOW_FREE:  i_out_stall <= 1'b0;
                    FLOW_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
                    FLOW_HEAVY: i_out_stall <= ($urandom_range(0, 9) < 7);
                    default:    i_out_stall <= (tick % 5 < 2);
                endcase
            end
        end
    end

    initial begin : stimulus
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: premultiply, 8-bit, RGB enabled, alpha from A
        send_pixel(pixel_of(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_pixel(pixel_of(1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send_pixel(pixel_of(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_pixel(pixel_of(1'b1, 16'h00FF, 16'h00FF, 16'h00FF, 16'h0000));
        send_pixel(pixel_of(1'b1, 16'hAA80, 16'h5540, 16'hFF01, 16'h3380));

        // 16-bit divide: zero alpha passes through, tiny alpha saturates
        apply_settings(1'b1, 1'b1, 4'hF, SRC_ALPHA);
        send_pixel(pixel_of(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_pixel(pixel_of(1'b1, 16'h1234, 16'hFFFF, 16'h0001, 16'h0000));
        send_pixel(pixel_of(1'b1, 16'hFFFF, 16'h8000, 16'h0001, 16'h0001));
        send_pixel(pixel_of(1'b1, 16'h7FFF, 16'h0001, 16'h4000, 16'h8000));
        send_pixel(pixel_of(1'b0, 16'h1111, 16'h2222, 16'h3333, 16'h4444));

        apply_settings(1'b1, 1'b0, 4'h5, SRC_RED);
        send_pixel(pixel_of(1'b1, 16'h0000, 16'h0080, 16'h00FF, 16'h0010));
        send_pixel(pixel_of(1'b1, 16'h0040, 16'h0080, 16'h00FF, 16'h0010));

        apply_settings(1'b0, 1'b1, 4'hF, SRC_BLUE);
        send_pixel(pixel_of(1'b1, 16'hFFFF, 16'h1234, 16'h8000, 16'h0001));

        apply_settings(1'b0, 1'b0, 4'hF, SRC_NONE);
        send_pixel(pixel_of(1'b1, 16'hFF12, 16'h0034, 16'h0056, 16'h0078));

        // selector codes past alpha behave as none
        for (int k = 1; k <= 3; k++) begin
            apply_settings(1'b0, 1'b0, 4'hF, SRC_ALPHA + 3'(k));
            send_pixel(pixel_of(1'b1, 16'h00C0, 16'h0080, 16'h0040, 16'h0020));
        end

        apply_settings(1'b1, 1'b0, 4'h0, SRC_GREEN);
        send_pixel(pixel_of(1'b1, 16'h0011, 16'h0022, 16'h0033, 16'h0044));

        // random traffic
        run_phase(1'b0, 1'b0, 4'hF, SRC_ALPHA, 50, 1'b1);

        apply_settings(1'b1, 1'b0, 4'hF, SRC_ALPHA);
        hold_request = HOLD_CYCLES;  // output held off while input keeps coming
        hold_count++;
        send_stream(60, 1'b0);

        run_phase(1'b0, 1'b1, 4'h7, SRC_ALPHA, 50, 1'b0);

        apply_settings(1'b1, 1'b1, 4'hF, SRC_ALPHA);
        send_stream(30, 1'b1);
        wait_drained();
        drain_count++;
        send_stream(30, 1'b1);

        run_phase(1'b1, 1'b1, 4'hB, SRC_GREEN, 50, 1'b1);
        run_phase(1'b0, 1'b0, 4'h0, SRC_RED, 40, 1'b1);
        run_phase(1'b1, 1'b0, 4'h8, SRC_BLUE, 50, 1'b0);
        run_phase(1'b0, 1'b0, 4'h0, SRC_NONE, 40, 1'b1);
        run_phase(1'b1, 1'b1, 4'hF, 3'h7, 50, 1'b1);
        for (int k = 0; k < 3; k++)
            run_phase(1'($urandom), 1'($urandom), 4'($urandom), 3'($urandom), 50, 1'b1);

        wait_drained();
        board.close_out();
        $display("run covered %0d pixel beats in, %0d out, over %0d register settings",
                 board.pixels_in, board.pixels_out, settings_count);
        $display("including %0d long output hold-off(s) and %0d mid-stream drain(s)",
                 hold_count, drain_count);
        if (board.failures == 0) begin
            $display("alpha_premultiply_unit regression: pass");
        end else begin
            $display("alpha_premultiply_unit regression: fail");
        end
        $finish;
    end

endmodule

// File: alpha_premultiply_unit.f
sv/apu_pkg.sv
sv/apu_lane.sv
sv/apu_merge.sv
sv/alpha_premultiply_unit.sv
sim/alpha_premultiply_unit_test.sv
